// ===== rtl/ihp_pkg.sv =====
// Shared constants for the indexed priority heap: field widths, default sizes, codes.
package ihp_pkg;

    localparam int ID_W        = 10;
    localparam int ID_SPACE    = 1 << ID_W;
    localparam int KEY_IN_W    = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int STATUS_W    = 3;
    localparam int OP_W        = 2;

    localparam int DEF_CAPACITY  = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 104;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH       = 2'd0,
        OP_POP        = 2'd1,
        OP_PRIORITIZE = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_POP_EMPTY = 3'd1,
        ST_FULL      = 3'd2,
        ST_ID_BAD    = 3'd3,
        ST_KEY_WORSE = 3'd4
    } status_t;

endpackage

// ===== rtl/ihp_heap_ram.sv =====
// Heap slot memory: one write port and two registered read ports.
module ihp_heap_ram #(
    parameter int AW = 11,
    parameter int DW = 42
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/ihp_pos_ram.sv =====
// Position map memory: slot of each id, one write port and one registered read port.
module ihp_pos_ram #(
    parameter int AW = 10,
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/indexed_priority_heap_unit.sv =====
// Top level of the indexed priority heap: control sequencer, memories and stream ports.
//
// This block keeps a binary heap of (key, id) pairs plus a map from every id to the heap
// slot that holds it. Each input word is a push, a pop of the top, a prioritize that
// gives a present id a better or equal key, or a no-op; each yields exactly one result
// word with the popped pair, the new top, the entry count and a status. Faults (pop when
// empty, push when full or of a present id, prioritize of an absent id or with a worse
// key) change nothing and are only reported. The register min_first picks smallest-first
// (1, reset) or largest-first (0) order; write it only while the block is idle. After
// reset the block clears every entry of the position map, whatever CAPACITY is, and
// holds s_tready low meanwhile. Each word passes through a lookup, any sift, a top read
// and a finish step; at each heap level walked by the sift the heap memory does a
// registered read, a compare and a write back, with the moving entry carried in
// registers so that each level costs one read and one write. A new word is taken once
// the previous one has been loaded into the output register, so a result may wait on
// m_tready while the next word is at work.
module indexed_priority_heap_unit #(
    parameter int CAPACITY  = ihp_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = ihp_pkg::DEF_KEY_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write: bit 0 is min_first.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    // s_tdata fields from bit 0: op[1:0], key[33:2], id[43:34], zero fill.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ihp_pkg::S_DATA_W-1:0]  s_tdata,
    // m_tdata fields from bit 0: status[2:0], popped_key[34:3], popped_id[44:35],
    // top_key[76:45], top_id[86:77], count[97:87], is_empty[98], zero fill.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ihp_pkg::M_DATA_W-1:0]  m_tdata
);

    import ihp_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int HW = KEY_WIDTH + ID_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_PRIREAD, S_UP, S_UPCMP,
        S_DOWN, S_DNCMP, S_PLACE, S_TOPRD, S_FIN
    } state_t;

    state_t                state_reg;
    logic [ID_W:0]         clr_cnt_reg;
    logic                  min_first_reg;
    logic [SW-1:0]         count_reg;
    op_t                   op_reg;
    logic [KEY_WIDTH-1:0]  cur_key_reg;
    logic [ID_W-1:0]       cur_id_reg;
    logic [SW-1:0]         cur_pos_reg;
    status_t               status_reg;
    logic [KEY_WIDTH-1:0]  pkey_reg;
    logic [ID_W-1:0]       pid_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    // Memory ports.
    logic                  heap_we;
    logic [SW-1:0]         heap_wa, heap_ra, heap_rb;
    logic [HW-1:0]         heap_wd, heap_qa, heap_qb;
    logic                  pos_we;
    logic [ID_W-1:0]       pos_wa, pos_ra;
    logic [SW-1:0]         pos_wd, pos_q;

    // Input fields.
    logic [OP_W-1:0]       in_op;
    logic [KEY_WIDTH-1:0]  in_key;
    logic [ID_W-1:0]       in_id;

    logic [KEY_WIDTH-1:0]  a_key, b_key;
    logic [ID_W-1:0]       a_id, b_id;
    logic [SW:0]           left_pos, right_pos;
    logic                  left_in, right_in, pick_left, pick_right;
    logic                  out_free;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_key = KEY_WIDTH'(s_tdata[OP_W +: KEY_IN_W]);
    assign in_id  = s_tdata[OP_W+KEY_IN_W +: ID_W];

    assign a_key = heap_qa[KEY_WIDTH-1:0];
    assign a_id  = heap_qa[KEY_WIDTH +: ID_W];
    assign b_key = heap_qb[KEY_WIDTH-1:0];
    assign b_id  = heap_qb[KEY_WIDTH +: ID_W];

    function automatic logic better(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic                 minf);
        return minf ? (a < b) : (a > b);
    endfunction

    // Children of the current hole during the downward sift.
    assign left_pos   = {cur_pos_reg, 1'b0};
    assign right_pos  = left_pos + (SW+1)'(1);
    assign left_in    = left_pos <= {1'b0, count_reg};
    assign right_in   = right_pos <= {1'b0, count_reg};
    assign pick_right = right_in && better(b_key, cur_key_reg, min_first_reg) &&
                        (!better(a_key, cur_key_reg, min_first_reg) ||
                         better(b_key, a_key, min_first_reg));
    assign pick_left  = !pick_right && better(a_key, cur_key_reg, min_first_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Memory addressing follows the sequencer state.
    always_comb begin
        heap_we = 1'b0;
        heap_wa = cur_pos_reg;
        heap_wd = {cur_id_reg, cur_key_reg};
        heap_ra = SW'(1);
        heap_rb = count_reg;
        pos_we  = 1'b0;
        pos_wa  = cur_id_reg;
        pos_wd  = cur_pos_reg;
        pos_ra  = in_id;
        unique case (state_reg)
            S_CLEAR: begin
                pos_we = 1'b1;
                pos_wa = clr_cnt_reg[ID_W-1:0];
                pos_wd = '0;
            end
            S_LOOKUP: begin
                if (op_reg == OP_PRIORITIZE) begin
                    heap_ra = pos_q;
                end else if (op_reg == OP_POP && count_reg != '0) begin
                    pos_we = 1'b1;
                    pos_wa = a_id;
                    pos_wd = '0;
                end
            end
            S_UP: begin
                heap_ra = cur_pos_reg >> 1;
            end
            S_UPCMP: begin
                if (better(cur_key_reg, a_key, min_first_reg)) begin
                    heap_we = 1'b1;
                    heap_wd = heap_qa;
                    pos_we  = 1'b1;
                    pos_wa  = a_id;
                end
            end
            S_DOWN: begin
                heap_ra = left_pos[SW-1:0];
                heap_rb = right_pos[SW-1:0];
            end
            S_DNCMP: begin
                if (pick_left || pick_right) begin
                    heap_we = 1'b1;
                    heap_wd = pick_right ? heap_qb : heap_qa;
                    pos_we  = 1'b1;
                    pos_wa  = pick_right ? b_id : a_id;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            min_first_reg <= 1'b1;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_first_reg <= cfg_data;
            end
            // In S_FIN the output register is reloaded instead.
            if (m_tvalid_reg && m_tready && state_reg != S_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + (ID_W+1)'(1);
                    if (clr_cnt_reg[ID_W-1:0] == '1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= op_t'(in_op);
                        cur_key_reg <= in_key;
                        cur_id_reg  <= in_id;
                        status_reg  <= ST_OK;
                        pkey_reg    <= '0;
                        pid_reg     <= '0;
                        state_reg   <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    state_reg <= S_TOPRD;
                    case (op_reg)
                        OP_PUSH: begin
                            if (count_reg >= SW'(CAPACITY)) begin
                                status_reg <= ST_FULL;
                            end else if (pos_q != '0) begin
                                status_reg <= ST_ID_BAD;
                            end else begin
                                count_reg   <= count_reg + SW'(1);
                                cur_pos_reg <= count_reg + SW'(1);
                                state_reg   <= S_UP;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_reg <= ST_POP_EMPTY;
                            end else begin
                                pkey_reg  <= a_key;
                                pid_reg   <= a_id;
                                count_reg <= count_reg - SW'(1);
                                if (count_reg != SW'(1)) begin
                                    cur_key_reg <= b_key;
                                    cur_id_reg  <= b_id;
                                    cur_pos_reg <= SW'(1);
                                    state_reg   <= S_DOWN;
                                end
                            end
                        end
                        OP_PRIORITIZE: begin
                            if (pos_q == '0 || pos_q > count_reg) begin
                                status_reg <= ST_ID_BAD;
                            end else begin
                                cur_pos_reg <= pos_q;
                                state_reg   <= S_PRIREAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_PRIREAD: begin
                    if (better(a_key, cur_key_reg, min_first_reg)) begin
                        status_reg <= ST_KEY_WORSE;
                        state_reg  <= S_TOPRD;
                    end else begin
                        state_reg <= S_UP;
                    end
                end
                S_UP: begin
                    state_reg <= (cur_pos_reg == SW'(1)) ? S_PLACE : S_UPCMP;
                end
                S_UPCMP: begin
                    if (better(cur_key_reg, a_key, min_first_reg)) begin
                        cur_pos_reg <= cur_pos_reg >> 1;
                        state_reg   <= S_UP;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_DOWN: begin
                    state_reg <= left_in ? S_DNCMP : S_PLACE;
                end
                S_DNCMP: begin
                    if (pick_right) begin
                        cur_pos_reg <= right_pos[SW-1:0];
                        state_reg   <= S_DOWN;
                    end else if (pick_left) begin
                        cur_pos_reg <= left_pos[SW-1:0];
                        state_reg   <= S_DOWN;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    state_reg <= S_TOPRD;
                end
                S_TOPRD: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0,
                                         (count_reg == '0),
                                         COUNT_OUT_W'(count_reg),
                                         (count_reg == '0) ? '0 : a_id,
                                         (count_reg == '0) ? '0 : KEY_IN_W'(a_key),
                                         pid_reg,
                                         KEY_IN_W'(pkey_reg),
                                         status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ihp_heap_ram #(.AW(SW), .DW(HW)) u_heap_ram (
        .aclk    (aclk),
        .we      (heap_we),
        .waddr   (heap_wa),
        .wdata   (heap_wd),
        .raddr_a (heap_ra),
        .raddr_b (heap_rb),
        .rdata_a (heap_qa),
        .rdata_b (heap_qb)
    );

    ihp_pos_ram #(.AW(ID_W), .DW(SW)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_wa),
        .wdata (pos_wd),
        .raddr (pos_ra),
        .rdata (pos_q)
    );

    // The entry count never exceeds the heap capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SW'(CAPACITY))
        else $error("entry count above capacity");

    // Once a word is taken the block is busy on the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");

    // The moving entry always sits on an occupied slot while it sifts up.
    a_hole_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UP) |-> (cur_pos_reg != '0 && cur_pos_reg <= count_reg))
        else $error("sift position outside the occupied slots");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for indexed_priority_heap_unit: directed table, fill, random traffic.
`timescale 1ns / 1ps

module tb_top;
    import ihp_pkg::*;

    localparam int CAP        = DEF_CAPACITY;
    localparam int DRAIN_WAIT = 40;
    localparam int STALL_LIM  = 4000;

    typedef struct {
        status_t         status;
        logic [31:0]     popped_key;
        logic [ID_W-1:0] popped_id;
        logic [31:0]     top_key;
        logic [ID_W-1:0] top_id;
        logic [10:0]     count;
        logic            is_empty;
    } heap_result_t;

    typedef struct {
        op_t             op;
        logic [31:0]     key;
        logic [ID_W-1:0] id;
        bit              fixed;
        status_t         fixed_status;
        logic [10:0]     fixed_count;
    } table_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    indexed_priority_heap_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the heap.
    logic [31:0]     heap_key [1:CAP];
    logic [ID_W-1:0] heap_id  [1:CAP];
    int              slot_of  [0:ID_SPACE-1];
    int              held;
    bit              smallest_first;

    heap_result_t pending_results[$];
    int errors, words_in, words_out, pops_done, faults_seen;
    bit quiet, hold_long;

    function automatic bit outranks(logic [31:0] a, logic [31:0] b);
        return smallest_first ? (a < b) : (a > b);
    endfunction

    function automatic void exchange(int a, int b);
        logic [31:0]     k;
        logic [ID_W-1:0] d;
        k = heap_key[a]; d = heap_id[a];
        heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
        heap_key[b] = k; heap_id[b] = d;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    function automatic void bubble_up(int i);
        while (i > 1 && outranks(heap_key[i], heap_key[i >> 1])) begin
            exchange(i, i >> 1);
            i = i >> 1;
        end
    endfunction

    function automatic void bubble_down(int i);
        int l, r, pick;
        forever begin
            l = 2 * i; r = l + 1; pick = 0;
            if (l <= held && outranks(heap_key[l], heap_key[i])) pick = l;
            if (r <= held && outranks(heap_key[r], heap_key[i]))
                if (pick == 0 || outranks(heap_key[r], heap_key[l])) pick = r;
            if (pick == 0) break;
            exchange(i, pick);
            i = pick;
        end
    endfunction

    // Applies one word to the shadow heap and returns the result it must produce.
    function automatic heap_result_t apply_word(op_t op, logic [31:0] key, logic [ID_W-1:0] id);
        heap_result_t r;
        int p;
        r = '{ST_OK, 0, 0, 0, 0, 0, 0};
        case (op)
            OP_PUSH: begin
                if (held >= CAP) r.status = ST_FULL;
                else if (slot_of[id] != 0) r.status = ST_ID_BAD;
                else begin
                    held++;
                    heap_key[held] = key; heap_id[held] = id;
                    slot_of[id] = held;
                    bubble_up(held);
                end
            end
            OP_POP: begin
                if (held == 0) r.status = ST_POP_EMPTY;
                else begin
                    r.popped_key = heap_key[1]; r.popped_id = heap_id[1];
                    slot_of[heap_id[1]] = 0;
                    if (held > 1) begin
                        heap_key[1] = heap_key[held]; heap_id[1] = heap_id[held];
                        slot_of[heap_id[1]] = 1;
                    end
                    held--;
                    bubble_down(1);
                end
            end
            OP_PRIORITIZE: begin
                p = slot_of[id];
                if (p == 0 || p > held) r.status = ST_ID_BAD;
                else if (outranks(heap_key[p], key)) r.status = ST_KEY_WORSE;
                else begin
                    heap_key[p] = key;
                    bubble_up(p);
                end
            end
            default: ;
        endcase
        if (held != 0) begin
            r.top_key = heap_key[1]; r.top_id = heap_id[1];
        end
        r.count = 11'(held);
        r.is_empty = (held == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH word %0d %s: got %0h expected %0h", words_out, field, got, want);
    endtask

    // Offers one word, waits for it to be taken, then records its expected result.
    task automatic send_word(op_t op, logic [31:0] key, logic [ID_W-1:0] id,
                             bit fixed = 0, status_t fst = ST_OK, logic [10:0] fcnt = 0);
        heap_result_t r;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, id, key, op};
        do @(posedge aclk); while (!s_tready);
        r = apply_word(op, key, id);
        if (fixed) begin
            r.status = fst;
            r.count = fcnt;
            r.is_empty = (fcnt == 0);
        end
        if (r.status != ST_OK) faults_seen++;
        if (op == OP_POP && r.status == ST_OK) pops_done++;
        pending_results.push_back(r);
        words_in++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // Waits for the block to go idle, then writes the order register.
    task automatic write_order(bit smallest);
        drop_valid();
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= smallest;
        do @(posedge aclk); while (!cfg_ready);
        smallest_first = smallest;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_words(int n);
        int pick, slot;
        logic [31:0] k;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                k = $urandom();
                if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                send_word(OP_PUSH, k, ID_W'($urandom_range(0, ID_SPACE - 1)));
            end else if (pick < 72) begin
                send_word(OP_POP, $urandom(), ID_W'($urandom()));
            end else if (pick < 92 && held > 0) begin
                // A present id given a better or equal key, mostly.
                slot = $urandom_range(1, held);
                k = heap_key[slot];
                if ($urandom_range(0, 5) == 0) k = k;
                else if (smallest_first) k = $urandom_range(0, k);
                else k = $urandom_range(k, 32'hFFFF_FFFF);
                send_word(OP_PRIORITIZE, k, heap_id[slot]);
            end else if (pick < 97) begin
                send_word(OP_PRIORITIZE, $urandom(), ID_W'($urandom_range(0, ID_SPACE - 1)));
            end else begin
                send_word(OP_NONE, $urandom(), ID_W'($urandom()));
            end
        end
    endtask

    // Result checker: every accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        heap_result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("MISMATCH result word %0d arrived with nothing expected", words_out);
            end else begin
                w = pending_results.pop_front();
                if (m_tdata[2:0] != w.status) report_mismatch("status", m_tdata[2:0], w.status);
                if (m_tdata[34:3] != w.popped_key)
                    report_mismatch("popped_key", m_tdata[34:3], w.popped_key);
                if (m_tdata[44:35] != w.popped_id)
                    report_mismatch("popped_id", m_tdata[44:35], w.popped_id);
                if (m_tdata[76:45] != w.top_key) report_mismatch("top_key", m_tdata[76:45], w.top_key);
                if (m_tdata[86:77] != w.top_id) report_mismatch("top_id", m_tdata[86:77], w.top_id);
                if (m_tdata[97:87] != w.count) report_mismatch("count", m_tdata[97:87], w.count);
                if (m_tdata[98] != w.is_empty) report_mismatch("is_empty", m_tdata[98], w.is_empty);
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when quiet.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_long = 0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles with no handshake on any channel.
    initial begin
        int still;
        still = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                still = 0;
            else
                still++;
            if (still >= STALL_LIM + CAP) begin
                $display("watchdog: no progress with %0d results outstanding",
                         pending_results.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    table_row_t directed[] = '{
        '{OP_POP,        32'h0,         10'd0,   1, ST_POP_EMPTY, 0},
        '{OP_PRIORITIZE, 32'h5,         10'd5,   1, ST_ID_BAD,    0},
        '{OP_NONE,       32'hFFFF_FFFF, 10'h3FF, 1, ST_OK,        0},
        '{OP_PUSH,       32'hFFFF_FFFF, 10'h3FF, 1, ST_OK,        1},
        '{OP_PUSH,       32'h0,         10'd0,   1, ST_OK,        2},
        '{OP_PUSH,       32'h0,         10'd7,   0, ST_OK,        0},
        '{OP_PUSH,       32'h1234,      10'h3FF, 1, ST_ID_BAD,    3},
        '{OP_PRIORITIZE, 32'h5,         10'h3FF, 0, ST_OK,        0},
        '{OP_PRIORITIZE, 32'h100,       10'h3FF, 1, ST_KEY_WORSE, 3},
        '{OP_PRIORITIZE, 32'h5,         10'h3FF, 1, ST_OK,        3},
        '{OP_PUSH,       32'hAAAA_5555, 10'h2AA, 0, ST_OK,        0},
        '{OP_PUSH,       32'h5555_AAAA, 10'h155, 0, ST_OK,        0},
        '{OP_PRIORITIZE, 32'h0,         10'h155, 0, ST_OK,        0},
        '{OP_POP,        32'hFFFF_FFFF, 10'h3FF, 0, ST_OK,        0},
        '{OP_POP,        32'h0,         10'd0,   0, ST_OK,        0},
        '{OP_POP,        32'h0,         10'd0,   0, ST_OK,        0},
        '{OP_POP,        32'h0,         10'd0,   0, ST_OK,        0},
        '{OP_POP,        32'h0,         10'd0,   1, ST_OK,        0},
        '{OP_POP,        32'h0,         10'd0,   1, ST_POP_EMPTY, 0},
        '{OP_PRIORITIZE, 32'h0,         10'h155, 1, ST_ID_BAD,    0}
    };

    initial begin
        int pushed;
        held = 0;
        pushed = 0;
        smallest_first = 1;
        foreach (slot_of[i]) slot_of[i] = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_order(1);
        foreach (directed[i])
            send_word(directed[i].op, directed[i].key, directed[i].id, directed[i].fixed,
                      directed[i].fixed_status, directed[i].fixed_count);
        random_words(130);

        // Push a run of fresh ids against a long receiver hold, then pop some back.
        hold_long = 1;
        for (int i = 0; i < ID_SPACE && pushed < 60; i++)
            if (slot_of[i] == 0) begin
                send_word(OP_PUSH, $urandom(), ID_W'(i));
                pushed++;
            end
        repeat (20) send_word(OP_POP, 0, 0);

        write_order(0);
        random_words(130);
        write_order(1);
        random_words(110);
        quiet = 1;
        random_words(80);
        drop_valid();

        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d words in both orders: %0d pops, %0d faults, long output hold",
                 words_in, pops_done, faults_seen);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
